[src/hmseq_pkg.sv]
package hmseq_pkg;

    // Command codes carried in the mode field.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_ABORT = 2'd2;

    // Homing phase codes, also reported in the phase field.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_XFAST = 3'd1;
    localparam logic [2:0] PH_XBACK = 3'd2;
    localparam logic [2:0] PH_XZERO = 3'd3;
    localparam logic [2:0] PH_YFAST = 3'd4;
    localparam logic [2:0] PH_YBACK = 3'd5;
    localparam logic [2:0] PH_YZERO = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FAST_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_BACKOFF_PERIOD = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT        = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  FAST_PERIOD_RST    = 8'd1;
    localparam logic [7:0]  BACKOFF_PERIOD_RST = 8'd8;
    localparam logic [15:0] TIMEOUT_RST        = 16'd30000;

    // Saturation value of the since-pulse counter.
    localparam logic [15:0] SINCE_PULSE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] mode;
        logic       x_alarm;
        logic       y_alarm;
        logic       motion_busy;
    } t_hs_in;

    typedef struct packed {
        logic       pulse_x;
        logic       pulse_y;
        logic       pulse_dir;
        logic       clear_alarm_x;
        logic       clear_alarm_y;
        logic       zero_x;
        logic       zero_y;
        logic       done_res;
        logic       timed_out;
        logic [2:0] phase;
        logic       alarm_stop;
        logic [1:0] alarm_code;
    } t_hs_out;

    typedef struct packed {
        logic [7:0]  fast_period_ms;
        logic [7:0]  backoff_period_ms;
        logic [15:0] timeout_ms;
    } t_hs_cfg;

    typedef struct packed {
        logic [2:0]  home_phase;
        logic [15:0] elapsed_ms;
        logic [15:0] since_pulse_ms;
        logic [7:0]  current_period;
    } t_hs_state;

endpackage

[src/hmseq_step.sv]
module hmseq_step
    import hmseq_pkg::*;
(
    input  t_hs_in    i_item,
    input  t_hs_state i_state,
    input  t_hs_cfg   i_cfg,
    output t_hs_state o_state,
    output t_hs_out   o_res
);

    logic [15:0] since_inc;
    logic        due;
    logic        timeout_hit;

    // Saturating tick count since the last pulse, and the pulse-due check.
    assign since_inc = (i_state.since_pulse_ms != SINCE_PULSE_MAX) ?
                       i_state.since_pulse_ms + 16'd1 : i_state.since_pulse_ms;
    assign due = since_inc >= {8'd0, i_state.current_period};
    assign timeout_hit = (i_state.home_phase != PH_IDLE) &&
                         (i_state.elapsed_ms >= i_cfg.timeout_ms);

    // One step of the homing sequence for the item at hand.
    always_comb begin
        o_state = i_state;
        o_res   = '0;

        unique case (i_item.mode)
            MODE_START: begin
                if (!i_item.motion_busy) begin
                    o_state.home_phase     = PH_XFAST;
                    o_state.current_period = i_cfg.fast_period_ms;
                    o_state.elapsed_ms     = '0;
                end
            end
            MODE_ABORT: begin
                o_state.home_phase = PH_IDLE;
                o_state.elapsed_ms = '0;
            end
            MODE_TICK: begin
                o_state.since_pulse_ms = since_inc;
                if (timeout_hit) begin
                    o_state.home_phase = PH_IDLE;
                    o_state.elapsed_ms = '0;
                    o_res.done_res     = 1'b1;
                    o_res.timed_out    = 1'b1;
                end else begin
                    if (i_state.home_phase != PH_IDLE) begin
                        o_state.elapsed_ms = i_state.elapsed_ms + 16'd1;
                    end
                    unique case (i_state.home_phase)
                        PH_IDLE: begin
                        end
                        PH_XFAST: begin
                            if (i_item.x_alarm) begin
                                o_res.clear_alarm_x    = 1'b1;
                                o_state.home_phase     = PH_XBACK;
                                o_state.current_period = i_cfg.backoff_period_ms;
                            end else if (due) begin
                                o_state.since_pulse_ms = '0;
                                o_res.pulse_x          = 1'b1;
                            end
                        end
                        PH_XBACK: begin
                            if (due) begin
                                o_state.since_pulse_ms = '0;
                                o_res.pulse_x          = 1'b1;
                                o_res.pulse_dir        = 1'b1;
                                o_state.home_phase     = PH_XZERO;
                            end
                        end
                        PH_XZERO: begin
                            o_res.zero_x           = 1'b1;
                            o_state.home_phase     = PH_YFAST;
                            o_state.current_period = i_cfg.fast_period_ms;
                        end
                        PH_YFAST: begin
                            if (i_item.y_alarm) begin
                                o_res.clear_alarm_y    = 1'b1;
                                o_state.home_phase     = PH_YBACK;
                                o_state.current_period = i_cfg.backoff_period_ms;
                            end else if (due) begin
                                o_state.since_pulse_ms = '0;
                                o_res.pulse_y          = 1'b1;
                            end
                        end
                        PH_YBACK: begin
                            if (due) begin
                                o_state.since_pulse_ms = '0;
                                o_res.pulse_y          = 1'b1;
                                o_res.pulse_dir        = 1'b1;
                                o_state.home_phase     = PH_YZERO;
                            end
                        end
                        PH_YZERO: begin
                            // Both axes are zeroed at the end of the Y pass.
                            o_res.zero_x       = 1'b1;
                            o_res.zero_y       = 1'b1;
                            o_state.home_phase = PH_DONE;
                        end
                        PH_DONE: begin
                            o_state.home_phase = PH_IDLE;
                            o_state.elapsed_ms = '0;
                            o_res.done_res     = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // Status fields follow the phase after the item.
        o_res.phase      = o_state.home_phase;
        o_res.alarm_stop = (o_state.home_phase == PH_IDLE) &&
                           (i_item.x_alarm || i_item.y_alarm);
        o_res.alarm_code = {i_item.y_alarm, i_item.x_alarm};
    end

endmodule

[src/two_axis_homing_sequencer.sv]
// An item passes from the input register through the one-pass step logic into
// the result register. One item per cycle while the output is ready; each
// register holds one item, and a stalled output holds both.
// Reset is synchronous and active low: it empties both registers, returns
// the sequence to idle and loads the configuration defaults.
module two_axis_homing_sequencer
    import hmseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_hs_in      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_hs_out     o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic      r_in_valid;
    t_hs_in    r_in;
    logic      r_out_valid;
    t_hs_out   r_out;
    t_hs_state r_state;
    t_hs_cfg   r_cfg;

    t_hs_state n_state;
    t_hs_out   n_out;
    logic      advance;

    // The step runs when the input register holds an item and the result
    // register is free or being emptied by an output transfer.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    hmseq_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result register and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{home_phase: PH_IDLE, elapsed_ms: '0,
                             since_pulse_ms: SINCE_PULSE_MAX, current_period: '0};
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{fast_period_ms: FAST_PERIOD_RST,
                       backoff_period_ms: BACKOFF_PERIOD_RST,
                       timeout_ms: TIMEOUT_RST};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAST_PERIOD:    r_cfg.fast_period_ms    <= i_cfg_data[7:0];
                CFG_BACKOFF_PERIOD: r_cfg.backoff_period_ms <= i_cfg_data[7:0];
                CFG_TIMEOUT:        r_cfg.timeout_ms        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A timeout result always reports done as well.
    a_timeout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.timed_out) |-> o_out_data.done_res)
        else $error("timed_out without done_res");

    // Only one axis is stepped per item.
    a_one_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.pulse_x && o_out_data.pulse_y))
        else $error("both axes pulsed");

    // The alarm stop is suppressed whenever homing is in progress.
    a_stop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.alarm_stop) |-> (o_out_data.phase == PH_IDLE))
        else $error("alarm_stop while homing");

    // The elapsed counter only runs during a sequence.
    a_idle_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.home_phase == PH_IDLE) |-> (r_state.elapsed_ms == '0))
        else $error("elapsed time nonzero while idle");
`endif

endmodule

[sim/two_axis_homing_sequencer_tb.sv]
`timescale 1ns / 1ps

module two_axis_homing_sequencer_tb;
    import hmseq_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int PIPE_LATENCY = 2;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_ITEMS  = 200;
    localparam int LONG_HOLD    = 250;
    localparam int MAX_REPORTS  = 10;

    // The mode code that the block leaves without effect.
    localparam logic [1:0] MODE_NOP = 2'd3;

    // One row of the directed table: either an item or a register write.
    typedef struct {
        bit          is_cfg;
        t_hs_in      item;
        bit          typed;
        t_hs_out     typed_exp;
        logic [1:0]  cfg_idx;
        logic [15:0] cfg_val;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_hs_in      i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_hs_out     o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    // Mirror of the sequencer state and its configuration.
    logic [2:0]  hs_phase;
    logic [15:0] hs_elapsed;
    logic [15:0] hs_since;
    logic [7:0]  hs_period;
    logic [7:0]  cfg_fast;
    logic [7:0]  cfg_back;
    logic [15:0] cfg_timeout;

    t_hs_out     expected_results[$];
    t_dir_row    directed_rows[$];
    int          mismatches = 0;
    int          rx_count = 0;
    int          items_counted = 0;
    int          cycle_count = 0;
    bit          no_gaps = 1'b0;

    two_axis_homing_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_hs_in hs_in(logic [1:0] m, logic xa, logic ya, logic busy);
        t_hs_in it;
        it.mode        = m;
        it.x_alarm     = xa;
        it.y_alarm     = ya;
        it.motion_busy = busy;
        return it;
    endfunction

    // Advance the mirrored sequencer by one item and return its result.
    function automatic t_hs_out step_homing(t_hs_in it);
        t_hs_out res;
        logic    due;
        res = '0;
        case (it.mode)
            MODE_START: begin
                if (!it.motion_busy) begin
                    hs_phase   = PH_XFAST;
                    hs_period  = cfg_fast;
                    hs_elapsed = '0;
                end
            end
            MODE_ABORT: begin
                hs_phase   = PH_IDLE;
                hs_elapsed = '0;
            end
            MODE_TICK: begin
                if (hs_since != SINCE_PULSE_MAX) hs_since = hs_since + 16'd1;
                due = (hs_since >= {8'd0, hs_period});
                if (hs_phase != PH_IDLE && hs_elapsed >= cfg_timeout) begin
                    hs_phase      = PH_IDLE;
                    hs_elapsed    = '0;
                    res.done_res  = 1'b1;
                    res.timed_out = 1'b1;
                end else begin
                    if (hs_phase != PH_IDLE) hs_elapsed = hs_elapsed + 16'd1;
                    case (hs_phase)
                        PH_XFAST: begin
                            if (it.x_alarm) begin
                                res.clear_alarm_x = 1'b1;
                                hs_phase  = PH_XBACK;
                                hs_period = cfg_back;
                            end else if (due) begin
                                hs_since    = '0;
                                res.pulse_x = 1'b1;
                            end
                        end
                        PH_XBACK: begin
                            if (due) begin
                                hs_since      = '0;
                                res.pulse_x   = 1'b1;
                                res.pulse_dir = 1'b1;
                                hs_phase      = PH_XZERO;
                            end
                        end
                        PH_XZERO: begin
                            res.zero_x = 1'b1;
                            hs_phase   = PH_YFAST;
                            hs_period  = cfg_fast;
                        end
                        PH_YFAST: begin
                            if (it.y_alarm) begin
                                res.clear_alarm_y = 1'b1;
                                hs_phase  = PH_YBACK;
                                hs_period = cfg_back;
                            end else if (due) begin
                                hs_since    = '0;
                                res.pulse_y = 1'b1;
                            end
                        end
                        PH_YBACK: begin
                            if (due) begin
                                hs_since      = '0;
                                res.pulse_y   = 1'b1;
                                res.pulse_dir = 1'b1;
                                hs_phase      = PH_YZERO;
                            end
                        end
                        PH_YZERO: begin
                            // Both axes are zeroed at the end of the Y leg.
                            res.zero_x = 1'b1;
                            res.zero_y = 1'b1;
                            hs_phase   = PH_DONE;
                        end
                        PH_DONE: begin
                            hs_phase     = PH_IDLE;
                            hs_elapsed   = '0;
                            res.done_res = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        res.phase      = hs_phase;
        res.alarm_stop = (hs_phase == PH_IDLE) && (it.x_alarm || it.y_alarm);
        res.alarm_code = {it.y_alarm, it.x_alarm};
        return res;
    endfunction

    // Offer one item, wait for its transfer, record the expected result,
    // then, unless gaps are off, idle for a random gap.
    task automatic send_item(input t_hs_in it, input bit typed, input t_hs_out typed_exp);
        t_hs_out predicted;
        int      gap;
        int      r;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = step_homing(it);
        expected_results.push_back(typed ? typed_exp : predicted);
        if (!(it.mode == MODE_NOP || (it.mode == MODE_START && it.motion_busy)))
            items_counted++;
        if (!no_gaps) begin
            r = $urandom_range(0, 99);
            if (r < 55) gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else if (r < 98) gap = $urandom_range(4, 10);
            else gap = $urandom_range(20, 60);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // One register write, after which the write port is left idle.
    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_FAST_PERIOD:    cfg_fast    = val[7:0];
            CFG_BACKOFF_PERIOD: cfg_back    = val[7:0];
            CFG_TIMEOUT:        cfg_timeout = val;
            default: ;
        endcase
    endtask

    task automatic add_row(input t_hs_in it, input bit typed, input t_hs_out e);
        t_dir_row row;
        row.is_cfg    = 1'b0;
        row.item      = it;
        row.typed     = typed;
        row.typed_exp = e;
        row.cfg_idx   = '0;
        row.cfg_val   = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [15:0] val);
        t_dir_row row;
        row.is_cfg    = 1'b1;
        row.item      = '0;
        row.typed     = 1'b0;
        row.typed_exp = '0;
        row.cfg_idx   = idx;
        row.cfg_val   = val;
        directed_rows.push_back(row);
    endtask

    // Result checker: every transfer on the output is matched against the
    // oldest expectation. Bits are in struct order, pulse_x first.
    initial begin
        t_hs_out want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                rx_count++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Result %b with no expectation at %0t", o_out_data, $realtime);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("Result mismatch at %0t: expected %b phase %0d, got %b phase %0d",
                                     $realtime, want, want.phase, o_out_data, o_out_data.phase);
                    end
                end
            end
        end
    end

    // Output side: random ready with stalls, bursts and two long hold-offs.
    initial begin
        int hold_left;
        int stall_left;
        int burst_left;
        int r;
        bit held_first;
        bit held_second;
        hold_left   = 0;
        stall_left  = 0;
        burst_left  = 0;
        held_first  = 1'b0;
        held_second = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!held_first && rx_count >= 300) begin
                held_first = 1'b1;
                hold_left  = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (!held_second && rx_count >= 900) begin
                held_second = 1'b1;
                hold_left   = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_out_ready <= 1'b1;
                end else if (r < 95) begin
                    i_out_ready <= 1'b0;
                end else if (r < 98) begin
                    stall_left = $urandom_range(5, 40);
                    i_out_ready <= 1'b0;
                end else begin
                    burst_left = $urandom_range(40, 150);
                    i_out_ready <= 1'b1;
                end
            end
            @(posedge i_clk);
        end
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run limit of %0d cycles reached", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus.
    initial begin
        logic [7:0]  set_fast;
        logic [7:0]  set_back;
        logic [15:0] set_timeout;
        t_hs_in      it;
        logic        xa;
        logic        ya;
        int          phase_end;
        int          phase_mid;
        int          run_cap;
        int          n;
        int          r;
        bit          paused;

        // Mirror the reset state.
        hs_phase    = PH_IDLE;
        hs_elapsed  = '0;
        hs_since    = SINCE_PULSE_MAX;
        hs_period   = '0;
        cfg_fast    = FAST_PERIOD_RST;
        cfg_back    = BACKOFF_PERIOD_RST;
        cfg_timeout = TIMEOUT_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Typed results list fields in struct order.
        // Idle tick, then alarms while idle raise the stop output.
        add_row(hs_in(MODE_TICK, 0, 0, 0), 1,
                t_hs_out'{0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0, 2'b00});
        add_row(hs_in(MODE_TICK, 1, 1, 1), 1,
                t_hs_out'{0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 1, 2'b11});
        // Abort while idle does nothing harmful.
        add_row(hs_in(MODE_ABORT, 1, 0, 0), 1,
                t_hs_out'{0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 1, 2'b01});
        // Unused mode.
        add_row(hs_in(MODE_NOP, 0, 1, 1), 1,
                t_hs_out'{0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 1, 2'b10});
        // Start while motion is busy is ignored.
        add_row(hs_in(MODE_START, 0, 0, 1), 1,
                t_hs_out'{0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0, 2'b00});
        add_cfg(CFG_BACKOFF_PERIOD, 16'd1);
        add_row(hs_in(MODE_START, 0, 0, 0), 1,
                t_hs_out'{0, 0, 0, 0, 0, 0, 0, 0, 0, PH_XFAST, 0, 2'b00});
        // A full X leg and Y leg, then done.
        add_row(hs_in(MODE_TICK, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 0, 1), 0, '0);
        add_row(hs_in(MODE_TICK, 1, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 1, 1, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 1, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 1, 0, 0), 0, '0);
        // Restart while homing, then abort.
        add_row(hs_in(MODE_START, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 1, 0, 0), 0, '0);
        add_row(hs_in(MODE_START, 0, 1, 0), 0, '0);
        add_row(hs_in(MODE_ABORT, 0, 0, 1), 1,
                t_hs_out'{0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE, 0, 2'b00});
        // Short timeout: the third tick after start aborts with a flag.
        add_cfg(CFG_TIMEOUT, 16'd2);
        add_row(hs_in(MODE_START, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 0, 0), 0, '0);
        add_row(hs_in(MODE_TICK, 0, 1, 0), 1,
                t_hs_out'{0, 0, 0, 0, 0, 0, 0, 1, 1, PH_IDLE, 1, 2'b10});

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                quiesce();
                write_cfg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].typed_exp);
            end
        end

        // Random part, one configuration per phase.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    set_fast    = 8'd0;
                    set_back    = 8'd0;
                    set_timeout = 16'd1;
                end
                1: begin
                    set_fast    = 8'd255;
                    set_back    = 8'd255;
                    set_timeout = 16'd65535;
                end
                2: begin
                    set_fast    = FAST_PERIOD_RST;
                    set_back    = BACKOFF_PERIOD_RST;
                    set_timeout = TIMEOUT_RST;
                end
                3: begin
                    set_fast    = 8'd2;
                    set_back    = 8'd3;
                    set_timeout = 16'd25;
                end
                default: begin
                    set_fast    = 8'($urandom_range(1, 20));
                    set_back    = 8'($urandom_range(1, 20));
                    set_timeout = 16'($urandom_range(20, 400));
                end
            endcase
            quiesce();
            write_cfg(CFG_FAST_PERIOD, {8'd0, set_fast});
            write_cfg(CFG_BACKOFF_PERIOD, {8'd0, set_back});
            write_cfg(CFG_TIMEOUT, set_timeout);
            no_gaps   = (p == 3);
            phase_end = items_counted + PHASE_ITEMS;
            phase_mid = items_counted + PHASE_ITEMS / 2;
            paused    = 1'b0;

            while (items_counted < phase_end) begin
                // Once per phase the sender waits for all results to return.
                if (!paused && items_counted >= phase_mid) begin
                    paused = 1'b1;
                    quiesce();
                end
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    // A homing run: start, then mostly ticks until it ends or the cap is hit.
                    send_item(hs_in(MODE_START, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 0), 0, '0);
                    run_cap = $urandom_range(20, 600);
                    n = 0;
                    while (n < run_cap && hs_phase != PH_IDLE && items_counted < phase_end) begin
                        if (hs_phase == PH_XFAST) xa = ($urandom_range(0, 5) == 0);
                        else xa = ($urandom_range(0, 19) == 0);
                        if (hs_phase == PH_YFAST) ya = ($urandom_range(0, 5) == 0);
                        else ya = ($urandom_range(0, 19) == 0);
                        if ($urandom_range(0, 49) == 0)
                            it = hs_in(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                        else
                            it = hs_in(MODE_TICK, xa, ya, 1'($urandom_range(0, 3) == 0));
                        send_item(it, 0, '0);
                        n++;
                    end
                end else begin
                    // Noise: fully random items.
                    repeat ($urandom_range(1, 10)) begin
                        send_item(hs_in(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))),
                                  0, '0);
                    end
                end
            end
        end

        quiesce();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
